/* src/blp_pkg.sv */
// ----------------------------------------------------------------------------
// blp_pkg: shared types and constants for the binomial lattice option pricer
// Holds field widths, fixed-point constants, register indexes, the controller
// state type and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package blp_pkg;

    // Field widths.
    localparam int PRICE_W  = 40;
    localparam int FACTOR_W = 32;
    localparam int PROB_W   = 31;
    localparam int STEPS_W  = 9;
    localparam int CFG_W    = 32;
    localparam int CFG_A_W  = 3;

    // Multiplier split: the 40-bit operand is handled as two 20-bit halves.
    localparam int HALF_W = PRICE_W / 2;
    localparam int PP_W   = HALF_W + FACTOR_W;
    localparam int FULL_W = PRICE_W + FACTOR_W;
    localparam int FRAC_SHIFT = 30;

    // Fixed-point constants.
    localparam logic [PRICE_W-1:0] PMAX    = {PRICE_W{1'b1}};
    localparam logic [PROB_W-1:0]  ONE_Q30 = PROB_W'(32'h4000_0000);

    // Reset values of the configuration registers.
    localparam logic [FACTOR_W-1:0] UP_RESET    = 32'h4000_0000;
    localparam logic [FACTOR_W-1:0] DOWN_RESET  = 32'h4000_0000;
    localparam logic [PROB_W-1:0]   PROB_RESET  = PROB_W'(32'h2000_0000);
    localparam logic [PROB_W-1:0]   DISC_RESET  = PROB_W'(32'h4000_0000);
    localparam logic [STEPS_W-1:0]  STEPS_RESET = STEPS_W'(64);

    localparam int DEFAULT_MAX_STEPS = 256;

    // Configuration register indexes.
    localparam logic [CFG_A_W-1:0] CFG_UP    = 3'd0;
    localparam logic [CFG_A_W-1:0] CFG_DOWN  = 3'd1;
    localparam logic [CFG_A_W-1:0] CFG_PROB  = 3'd2;
    localparam logic [CFG_A_W-1:0] CFG_DISC  = 3'd3;
    localparam logic [CFG_A_W-1:0] CFG_STEPS = 3'd4;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_TERM_INIT,
        ST_ASSET,
        ST_ASSET_UPD,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_MUL_FIN,
        ST_TERM_WRITE,
        ST_ROW_INIT,
        ST_NODE_RDA,
        ST_NODE_MA,
        ST_NODE_T1,
        ST_NODE_MB,
        ST_NODE_SUM,
        ST_NODE_MC,
        ST_NODE_CONT,
        ST_NODE_EX,
        ST_NODE_WR,
        ST_FIN_RD,
        ST_FIN_OUT
    } state_t;

    // Multiplier operand selects.
    typedef enum logic [1:0] {
        XSEL_ACC,
        XSEL_RD,
        XSEL_SUM
    } xsel_t;

    typedef enum logic [2:0] {
        FSEL_UP,
        FSEL_DOWN,
        FSEL_P,
        FSEL_Q,
        FSEL_DISC
    } fsel_t;

    typedef struct packed {
        logic  load_item;
        logic  acc_spot;
        logic  acc_from_mul;
        logic  mul_start;
        xsel_t x_sel;
        fsel_t f_sel;
        logic  mul_lo;
        logic  mul_hi;
        logic  mul_fin;
        logic  t1_load;
        logic  sum_load;
        logic  cont_load;
        logic  cont_max;
        logic  mem_rd;
        logic  mem_wr;
        logic  wr_cont;
        logic  out_load;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic amer;
    } status_t;

endpackage

/* src/blp_ctrl.sv */
// ----------------------------------------------------------------------------
// blp_ctrl: lattice sequencer
// Walks terminal payoff fill, backward induction rows and the multiplier
// phases, issuing commands to the datapath.
// ----------------------------------------------------------------------------
module blp_ctrl #(
    parameter int MAX_STEPS = blp_pkg::DEFAULT_MAX_STEPS,
    parameter int NW        = $clog2(MAX_STEPS + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [blp_pkg::CFG_A_W-1:0] cfg_addr,
    input  logic [blp_pkg::CFG_W-1:0]   cfg_wdata,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  blp_pkg::status_t            status,
    output blp_pkg::cmd_t               cmd,
    output logic [NW-1:0]               addr
);

    localparam int CW = (NW > blp_pkg::STEPS_W) ? NW : blp_pkg::STEPS_W;

    blp_pkg::state_t state_reg, state_next;
    blp_pkg::state_t mret_reg, mret_next;
    blp_pkg::state_t aret_reg, aret_next;
    logic [blp_pkg::STEPS_W-1:0] steps_reg;
    logic [NW-1:0] n_reg, n_next;
    logic [NW-1:0] s_reg, s_next;
    logic [NW-1:0] i_reg, i_next;
    logic [NW-1:0] k_reg, k_next;
    logic [NW-1:0] d_reg, d_next;
    logic [CW-1:0] steps_ext;
    logic [CW-1:0] max_ext;
    logic [NW-1:0] n_clamp;
    logic [NW-1:0] row;

    // Step count limited to the built lattice size.
    assign steps_ext = CW'(steps_reg);
    assign max_ext   = CW'(MAX_STEPS);
    always_comb
    begin
        if (steps_ext > max_ext)
            n_clamp = max_ext[NW-1:0];
        else
            n_clamp = steps_ext[NW-1:0];
    end

    assign row = s_reg - NW'(1);

    // Step count register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            steps_reg <= blp_pkg::STEPS_RESET;
        else if (cfg_wr_en && cfg_addr == blp_pkg::CFG_STEPS)
            steps_reg <= cfg_wdata[blp_pkg::STEPS_W-1:0];
    end

    // State and loop counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= blp_pkg::ST_IDLE;
            mret_reg  <= blp_pkg::ST_IDLE;
            aret_reg  <= blp_pkg::ST_IDLE;
            n_reg     <= '0;
            s_reg     <= '0;
            i_reg     <= '0;
            k_reg     <= '0;
            d_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            mret_reg  <= mret_next;
            aret_reg  <= aret_next;
            n_reg     <= n_next;
            s_reg     <= s_next;
            i_reg     <= i_next;
            k_reg     <= k_next;
            d_reg     <= d_next;
        end
    end

    // Next state and counter updates.
    always_comb
    begin
        state_next = state_reg;
        mret_next  = mret_reg;
        aret_next  = aret_reg;
        n_next     = n_reg;
        s_next     = s_reg;
        i_next     = i_reg;
        k_next     = k_reg;
        d_next     = d_reg;
        case (state_reg)
            blp_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    n_next     = n_clamp;
                    i_next     = '0;
                    state_next = blp_pkg::ST_TERM_INIT;
                end
            end
            blp_pkg::ST_TERM_INIT:
            begin
                k_next     = n_reg - i_reg;
                d_next     = i_reg;
                aret_next  = blp_pkg::ST_TERM_WRITE;
                state_next = blp_pkg::ST_ASSET;
            end
            blp_pkg::ST_ASSET:
            begin
                if (k_reg != '0)
                begin
                    k_next     = k_reg - NW'(1);
                    mret_next  = blp_pkg::ST_ASSET_UPD;
                    state_next = blp_pkg::ST_MUL_LO;
                end
                else if (d_reg != '0)
                begin
                    d_next     = d_reg - NW'(1);
                    mret_next  = blp_pkg::ST_ASSET_UPD;
                    state_next = blp_pkg::ST_MUL_LO;
                end
                else
                    state_next = aret_reg;
            end
            blp_pkg::ST_ASSET_UPD: state_next = blp_pkg::ST_ASSET;
            blp_pkg::ST_MUL_LO:    state_next = blp_pkg::ST_MUL_HI;
            blp_pkg::ST_MUL_HI:    state_next = blp_pkg::ST_MUL_FIN;
            blp_pkg::ST_MUL_FIN:   state_next = mret_reg;
            blp_pkg::ST_TERM_WRITE:
            begin
                if (i_reg == n_reg)
                begin
                    s_next = n_reg;
                    if (n_reg == '0)
                        state_next = blp_pkg::ST_FIN_RD;
                    else
                        state_next = blp_pkg::ST_ROW_INIT;
                end
                else
                begin
                    i_next     = i_reg + NW'(1);
                    state_next = blp_pkg::ST_TERM_INIT;
                end
            end
            blp_pkg::ST_ROW_INIT:
            begin
                i_next     = '0;
                state_next = blp_pkg::ST_NODE_RDA;
            end
            blp_pkg::ST_NODE_RDA: state_next = blp_pkg::ST_NODE_MA;
            blp_pkg::ST_NODE_MA:
            begin
                mret_next  = blp_pkg::ST_NODE_T1;
                state_next = blp_pkg::ST_MUL_LO;
            end
            blp_pkg::ST_NODE_T1: state_next = blp_pkg::ST_NODE_MB;
            blp_pkg::ST_NODE_MB:
            begin
                mret_next  = blp_pkg::ST_NODE_SUM;
                state_next = blp_pkg::ST_MUL_LO;
            end
            blp_pkg::ST_NODE_SUM: state_next = blp_pkg::ST_NODE_MC;
            blp_pkg::ST_NODE_MC:
            begin
                mret_next  = blp_pkg::ST_NODE_CONT;
                state_next = blp_pkg::ST_MUL_LO;
            end
            blp_pkg::ST_NODE_CONT:
            begin
                if (status.amer)
                begin
                    k_next     = row - i_reg;
                    d_next     = i_reg;
                    aret_next  = blp_pkg::ST_NODE_EX;
                    state_next = blp_pkg::ST_ASSET;
                end
                else
                    state_next = blp_pkg::ST_NODE_WR;
            end
            blp_pkg::ST_NODE_EX: state_next = blp_pkg::ST_NODE_WR;
            blp_pkg::ST_NODE_WR:
            begin
                if (i_reg == row)
                begin
                    s_next = row;
                    if (row == '0)
                        state_next = blp_pkg::ST_FIN_RD;
                    else
                        state_next = blp_pkg::ST_ROW_INIT;
                end
                else
                begin
                    i_next     = i_reg + NW'(1);
                    state_next = blp_pkg::ST_NODE_RDA;
                end
            end
            blp_pkg::ST_FIN_RD: state_next = blp_pkg::ST_FIN_OUT;
            blp_pkg::ST_FIN_OUT:
            begin
                if (status.out_free)
                    state_next = blp_pkg::ST_IDLE;
            end
            default: state_next = blp_pkg::ST_IDLE;
        endcase
    end

    // Datapath commands per state.
    always_comb
    begin
        cmd      = '0;
        addr     = i_reg;
        in_ready = 1'b0;
        case (state_reg)
            blp_pkg::ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_item = in_valid;
            end
            blp_pkg::ST_TERM_INIT: cmd.acc_spot = 1'b1;
            blp_pkg::ST_ASSET:
            begin
                cmd.x_sel = blp_pkg::XSEL_ACC;
                if (k_reg != '0)
                begin
                    cmd.mul_start = 1'b1;
                    cmd.f_sel     = blp_pkg::FSEL_UP;
                end
                else if (d_reg != '0)
                begin
                    cmd.mul_start = 1'b1;
                    cmd.f_sel     = blp_pkg::FSEL_DOWN;
                end
            end
            blp_pkg::ST_ASSET_UPD: cmd.acc_from_mul = 1'b1;
            blp_pkg::ST_MUL_LO:    cmd.mul_lo = 1'b1;
            blp_pkg::ST_MUL_HI:    cmd.mul_hi = 1'b1;
            blp_pkg::ST_MUL_FIN:   cmd.mul_fin = 1'b1;
            blp_pkg::ST_TERM_WRITE: cmd.mem_wr = 1'b1;
            blp_pkg::ST_NODE_RDA:  cmd.mem_rd = 1'b1;
            blp_pkg::ST_NODE_MA:
            begin
                cmd.mul_start = 1'b1;
                cmd.x_sel     = blp_pkg::XSEL_RD;
                cmd.f_sel     = blp_pkg::FSEL_P;
            end
            blp_pkg::ST_NODE_T1:
            begin
                cmd.t1_load = 1'b1;
                cmd.mem_rd  = 1'b1;
                addr        = i_reg + NW'(1);
            end
            blp_pkg::ST_NODE_MB:
            begin
                cmd.mul_start = 1'b1;
                cmd.x_sel     = blp_pkg::XSEL_RD;
                cmd.f_sel     = blp_pkg::FSEL_Q;
            end
            blp_pkg::ST_NODE_SUM: cmd.sum_load = 1'b1;
            blp_pkg::ST_NODE_MC:
            begin
                cmd.mul_start = 1'b1;
                cmd.x_sel     = blp_pkg::XSEL_SUM;
                cmd.f_sel     = blp_pkg::FSEL_DISC;
            end
            blp_pkg::ST_NODE_CONT:
            begin
                cmd.cont_load = 1'b1;
                cmd.acc_spot  = status.amer;
            end
            blp_pkg::ST_NODE_EX: cmd.cont_max = 1'b1;
            blp_pkg::ST_NODE_WR:
            begin
                cmd.mem_wr  = 1'b1;
                cmd.wr_cont = 1'b1;
            end
            blp_pkg::ST_FIN_RD:
            begin
                cmd.mem_rd = 1'b1;
                addr       = '0;
            end
            blp_pkg::ST_FIN_OUT: cmd.out_load = status.out_free;
            default: cmd = '0;
        endcase
    end

endmodule

/* src/blp_dp.sv */
// ----------------------------------------------------------------------------
// blp_dp: lattice datapath
// Factor registers, the shared 20x32 multiplier, the node store, payoff and
// saturation logic and the result register.
// ----------------------------------------------------------------------------
module blp_dp #(
    parameter int MAX_STEPS = blp_pkg::DEFAULT_MAX_STEPS,
    parameter int NW        = $clog2(MAX_STEPS + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [blp_pkg::CFG_A_W-1:0]   cfg_addr,
    input  logic [blp_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic [2*blp_pkg::PRICE_W-1:0] in_data,
    input  logic [1:0]                    in_user,
    input  blp_pkg::cmd_t                 cmd,
    input  logic [NW-1:0]                 addr,
    output blp_pkg::status_t              status,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [blp_pkg::PRICE_W-1:0]   out_price,
    output logic                          out_sat
);

    localparam int PW = blp_pkg::PRICE_W;
    localparam int FW = blp_pkg::FACTOR_W;
    localparam int QW = blp_pkg::PROB_W;
    localparam int HW = blp_pkg::HALF_W;

    logic [FW-1:0] up_reg, down_reg;
    logic [QW-1:0] prob_cfg_reg, disc_cfg_reg;
    logic [QW-1:0] p_reg, q_reg, disc_reg;
    logic [PW-1:0] spot_reg, strike_reg;
    logic          call_reg, amer_reg;
    logic [PW-1:0] acc_reg, t1_reg, sum_reg, cont_reg, rd_reg, mres_reg;
    logic [PW-1:0] mx_reg;
    logic [FW-1:0] mf_reg;
    logic [blp_pkg::PP_W-1:0] p0_reg, p1_reg;
    logic          ovf_reg;
    logic          out_valid_reg;
    logic [PW-1:0] price_reg;
    logic          sat_reg;
    logic [PW-1:0] mem [0:MAX_STEPS];

    logic [PW-1:0] x_mux;
    logic [FW-1:0] f_mux;
    logic [blp_pkg::FULL_W-1:0] full;
    logic [blp_pkg::FULL_W-blp_pkg::FRAC_SHIFT-1:0] shifted;
    logic          mul_clip;
    logic [PW-1:0] mul_val;
    logic [PW:0]   sum_wide;
    logic          sum_clip;
    logic [PW-1:0] payoff;
    logic [PW-1:0] wdata;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_reg       <= blp_pkg::UP_RESET;
            down_reg     <= blp_pkg::DOWN_RESET;
            prob_cfg_reg <= blp_pkg::PROB_RESET;
            disc_cfg_reg <= blp_pkg::DISC_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                blp_pkg::CFG_UP:   up_reg       <= cfg_wdata;
                blp_pkg::CFG_DOWN: down_reg     <= cfg_wdata;
                blp_pkg::CFG_PROB: prob_cfg_reg <= cfg_wdata[QW-1:0];
                blp_pkg::CFG_DISC: disc_cfg_reg <= cfg_wdata[QW-1:0];
                default: ;
            endcase
        end
    end

    // Item capture with probability and discount limited to one.
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            spot_reg   <= in_data[PW-1:0];
            strike_reg <= in_data[2*PW-1:PW];
            call_reg   <= in_user[0];
            amer_reg   <= in_user[1];
            if (prob_cfg_reg > blp_pkg::ONE_Q30)
            begin
                p_reg <= blp_pkg::ONE_Q30;
                q_reg <= '0;
            end
            else
            begin
                p_reg <= prob_cfg_reg;
                q_reg <= blp_pkg::ONE_Q30 - prob_cfg_reg;
            end
            if (disc_cfg_reg > blp_pkg::ONE_Q30)
                disc_reg <= blp_pkg::ONE_Q30;
            else
                disc_reg <= disc_cfg_reg;
        end
    end

    // Multiplier operand selection.
    always_comb
    begin
        case (cmd.x_sel)
            blp_pkg::XSEL_ACC: x_mux = acc_reg;
            blp_pkg::XSEL_RD:  x_mux = rd_reg;
            blp_pkg::XSEL_SUM: x_mux = sum_reg;
            default:           x_mux = acc_reg;
        endcase
        case (cmd.f_sel)
            blp_pkg::FSEL_UP:   f_mux = up_reg;
            blp_pkg::FSEL_DOWN: f_mux = down_reg;
            blp_pkg::FSEL_P:    f_mux = FW'(p_reg);
            blp_pkg::FSEL_Q:    f_mux = FW'(q_reg);
            blp_pkg::FSEL_DISC: f_mux = FW'(disc_reg);
            default:            f_mux = up_reg;
        endcase
    end

    // Product recombination, scaling by 2^-30 and clipping.
    assign full     = {p1_reg, {HW{1'b0}}} + blp_pkg::FULL_W'(p0_reg);
    assign shifted  = full[blp_pkg::FULL_W-1:blp_pkg::FRAC_SHIFT];
    assign mul_clip = (shifted[$bits(shifted)-1:PW] != '0);
    assign mul_val  = mul_clip ? blp_pkg::PMAX : shifted[PW-1:0];

    // Sum of the two weighted children, clipped.
    assign sum_wide = {1'b0, t1_reg} + {1'b0, mres_reg};
    assign sum_clip = sum_wide[PW];

    // Intrinsic value of the accumulated asset price.
    always_comb
    begin
        if (call_reg)
            payoff = (acc_reg > strike_reg) ? acc_reg - strike_reg : '0;
        else
            payoff = (strike_reg > acc_reg) ? strike_reg - acc_reg : '0;
    end

    assign wdata = cmd.wr_cont ? cont_reg : payoff;

    // Multiplier phases and working registers.
    always_ff @(posedge clk)
    begin
        if (cmd.mul_start)
        begin
            mx_reg <= x_mux;
            mf_reg <= f_mux;
        end
        if (cmd.mul_lo)
            p0_reg <= mx_reg[HW-1:0] * mf_reg;
        if (cmd.mul_hi)
            p1_reg <= mx_reg[PW-1:HW] * mf_reg;
        if (cmd.mul_fin)
            mres_reg <= mul_val;
        if (cmd.acc_spot)
            acc_reg <= spot_reg;
        else if (cmd.acc_from_mul)
            acc_reg <= mres_reg;
        if (cmd.t1_load)
            t1_reg <= mres_reg;
        if (cmd.sum_load)
            sum_reg <= sum_clip ? blp_pkg::PMAX : sum_wide[PW-1:0];
        if (cmd.cont_load)
            cont_reg <= mres_reg;
        else if (cmd.cont_max && payoff > cont_reg)
            cont_reg <= payoff;
    end

    // Node store.
    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr)
            mem[addr] <= wdata;
        if (cmd.mem_rd)
            rd_reg <= mem[addr];
    end

    // Saturation flag for the current item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovf_reg <= 1'b0;
        else if (cmd.load_item)
            ovf_reg <= 1'b0;
        else if ((cmd.mul_fin && mul_clip) || (cmd.sum_load && sum_clip))
            ovf_reg <= 1'b1;
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            price_reg <= rd_reg;
            sat_reg   <= ovf_reg;
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign status.amer     = amer_reg;
    assign out_valid       = out_valid_reg;
    assign out_price       = price_reg;
    assign out_sat         = sat_reg;

endmodule

/* src/binomial_lattice_option_pricer.sv */
// Per option, n = min(steps_in_use, MAX_STEPS). The sequencer first fills the terminal row,
// building each asset price by repeated up and down factor multiplies, then walks the rows
// by backward induction; American mode rebuilds the asset price at each node for exercise.
// Accept, the final read and the result load close the option. One option is in work at a time; the
// next is accepted once the result is registered. The shared 20x32 multiplier sets the rate.
// Reset (rst_n, async low) returns the sequencer to idle and loads register defaults.
// ----------------------------------------------------------------------------
// binomial_lattice_option_pricer: binomial lattice option pricer top level
// Prices one option per request by backward induction over a node store.
// ----------------------------------------------------------------------------
module binomial_lattice_option_pricer #(
    parameter int MAX_STEPS = blp_pkg::DEFAULT_MAX_STEPS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [blp_pkg::CFG_A_W-1:0]   cfg_addr,
    input  logic [blp_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [2*blp_pkg::PRICE_W-1:0] s_tdata,  // spot, strike
    input  logic [1:0]                    s_tuser,  // is_call, early_ex
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [blp_pkg::PRICE_W-1:0]   m_tdata,  // price
    output logic [0:0]                    m_tuser   // saturated
);

    localparam int NW = $clog2(MAX_STEPS + 1);

    blp_pkg::cmd_t    cmd;
    blp_pkg::status_t status;
    logic [NW-1:0]    addr;

    blp_ctrl #(
        .MAX_STEPS (MAX_STEPS),
        .NW        (NW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .status    (status),
        .cmd       (cmd),
        .addr      (addr)
    );

    blp_dp #(
        .MAX_STEPS (MAX_STEPS),
        .NW        (NW)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_data   (s_tdata),
        .in_user   (s_tuser),
        .cmd       (cmd),
        .addr      (addr),
        .status    (status),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_price (m_tdata),
        .out_sat   (m_tuser[0])
    );

endmodule

/* src/blp_checker.sv */
// ----------------------------------------------------------------------------
// blp_checker: port-level checks for the option pricer
// Watches the request and result channels over time.
// ----------------------------------------------------------------------------
module blp_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [blp_pkg::PRICE_W-1:0]   m_tdata,
    input logic [0:0]                    m_tuser
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result payload changed while stalled");

    // An accepted request makes the block busy.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while still busy");

    // A new result only comes out of a busy period.
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result without work in progress");

endmodule

bind binomial_lattice_option_pricer blp_checker u_blp_checker (.*);
